FILE: design/mqsb_pkg.sv
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared constants and codes for the multi-queue shared buffer.
// ----------------------------------------------------------------------------
package mqsb_pkg;

    localparam int QUEUES     = 4;
    localparam int SLOTS      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int QID_W  = 2;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int PTR_W  = $clog2(SLOTS + 1);

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [SLOT_W-1:0] slot_t;

    localparam ptr_t PTR_NIL = PTR_W'(SLOTS);

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

endpackage

FILE: design/mqsb_ram.sv
// ----------------------------------------------------------------------------
// mqsb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mqsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/multi_queue_shared_buffer.sv
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer
// Several FIFO queues kept as linked lists in one shared slot store.
// ----------------------------------------------------------------------------
// Each request is a push or a pop on one queue and yields one response. A
// request first reads the slot link and data memories at the free-list head
// (push) or the queue head (pop), then writes back the updated link, data,
// head, tail and free pointers. No new request is taken until the previous
// one has written back; a held response stalls the write-back cycle. Push on
// a full store or an out-of-range queue reports overflow, pop on an empty
// or out-of-range queue reports underflow; neither changes any state.
module multi_queue_shared_buffer
    import mqsb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic                    op,
    input  logic [QID_W-1:0]        queue_id,
    input  logic signed [VAL_W-1:0] value,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic [STAT_W-1:0]       status,
    output logic signed [VAL_W-1:0] popped_value,
    output logic                    queue_empty,
    output logic                    store_full
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                  state_reg, state_next;
    ptr_t                  free_head_reg, free_head_next;
    ptr_t                  queue_head_reg [QUEUES];
    ptr_t                  queue_tail_reg [QUEUES];
    logic [SLOTS-1:0]      link_vld_reg;

    logic                  op_reg;
    logic [QID_W-1:0]      qid_reg;
    logic [VAL_W-1:0]      value_reg;
    slot_t                 rd_slot_reg;
    logic                  rd_vld_reg;

    logic                  rsp_valid_reg;
    logic [STAT_W-1:0]     status_reg;
    logic [VAL_W-1:0]      popped_reg;
    logic                  qempty_reg;
    logic                  full_reg;

    logic                  accept;
    logic                  in_q_ok;
    ptr_t                  rd_ptr;
    logic                  finish;

    logic                  q_ok;
    logic [QIDX_W-1:0]     qi;
    ptr_t                  head_q;
    ptr_t                  tail_q;
    ptr_t                  link_rd;
    logic [PTR_W-1:0]      link_ram_rd;
    logic [DATA_WIDTH-1:0] data_rd;

    logic                  link_we;
    slot_t                 link_waddr;
    ptr_t                  link_wdata;
    logic                  data_we;
    logic                  head_we;
    ptr_t                  head_wdata;
    logic                  tail_we;

    logic [STAT_W-1:0]     status_c;
    logic [VAL_W-1:0]      popped_c;
    logic                  qempty_c;

    assign req_stall    = (state_reg != ST_IDLE);
    assign accept       = req_valid && !req_stall;
    assign finish       = (state_reg == ST_EXEC) && !(rsp_valid_reg && rsp_stall);

    assign in_q_ok = (32'(queue_id) < 32'(QUEUES));
    assign rd_ptr  = (op == OP_PUSH) ? free_head_reg
                                     : (in_q_ok ? queue_head_reg[queue_id[QIDX_W-1:0]]
                                                : PTR_NIL);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign q_ok    = (32'(qid_reg) < 32'(QUEUES));
    assign qi      = qid_reg[QIDX_W-1:0];
    assign head_q  = q_ok ? queue_head_reg[qi] : PTR_NIL;
    assign tail_q  = queue_tail_reg[qi];
    assign link_rd = rd_vld_reg ? link_ram_rd : (PTR_W'(rd_slot_reg) + PTR_W'(1));

    always_comb
    begin
        free_head_next = free_head_reg;
        link_we        = 1'b0;
        link_waddr     = tail_q[SLOT_W-1:0];
        link_wdata     = free_head_reg[PTR_W-1:0];
        data_we        = 1'b0;
        head_we        = 1'b0;
        head_wdata     = head_q;
        tail_we        = 1'b0;
        status_c       = STAT_OK;
        popped_c       = '0;
        qempty_c       = 1'b1;
        if (op_reg == OP_PUSH)
        begin
            if (!q_ok || (free_head_reg >= PTR_NIL))
            begin
                status_c = STAT_OVERFLOW;
                qempty_c = (head_q >= PTR_NIL);
            end
            else
            begin
                free_head_next = link_rd;
                data_we        = 1'b1;
                tail_we        = 1'b1;
                qempty_c       = 1'b0;
                if (head_q >= PTR_NIL)
                begin
                    head_we    = 1'b1;
                    head_wdata = free_head_reg;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = tail_q[SLOT_W-1:0];
                    link_wdata = free_head_reg;
                end
            end
        end
        else
        begin
            if (head_q >= PTR_NIL)
            begin
                status_c = STAT_UNDERFLOW;
                qempty_c = 1'b1;
            end
            else
            begin
                popped_c       = VAL_W'($signed(data_rd));
                head_we        = 1'b1;
                head_wdata     = (head_q == tail_q) ? PTR_NIL : link_rd;
                link_we        = 1'b1;
                link_waddr     = head_q[SLOT_W-1:0];
                link_wdata     = free_head_reg;
                free_head_next = head_q;
                qempty_c       = (head_wdata >= PTR_NIL);
            end
        end
    end

    mqsb_ram #(
        .WIDTH (PTR_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (finish && link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_en   (accept),
        .rd_addr (rd_ptr[SLOT_W-1:0]),
        .rd_data (link_ram_rd)
    );

    mqsb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (finish && data_we),
        .wr_addr (free_head_reg[SLOT_W-1:0]),
        .wr_data (DATA_WIDTH'($signed(value_reg))),
        .rd_en   (accept),
        .rd_addr (rd_ptr[SLOT_W-1:0]),
        .rd_data (data_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_head_reg <= '0;
            link_vld_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < QUEUES; i++)
            begin
                queue_head_reg[i] <= PTR_NIL;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                free_head_reg <= free_head_next;
                if (link_we)
                begin
                    link_vld_reg[link_waddr] <= 1'b1;
                end
                if (head_we)
                begin
                    queue_head_reg[qi] <= head_wdata;
                end
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op;
            qid_reg     <= queue_id;
            value_reg   <= value;
            rd_slot_reg <= rd_ptr[SLOT_W-1:0];
            rd_vld_reg  <= (rd_ptr < PTR_NIL) ? link_vld_reg[rd_ptr[SLOT_W-1:0]] : 1'b0;
        end
        if (finish)
        begin
            if (tail_we)
            begin
                queue_tail_reg[qi] <= free_head_reg;
            end
            status_reg <= status_c;
            popped_reg <= popped_c;
            qempty_reg <= qempty_c;
            full_reg   <= (free_head_next >= PTR_NIL);
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign queue_empty  = qempty_reg;
    assign store_full   = full_reg;

endmodule
